// ===== rtl/quadratic_real_roots_defines.svh =====
// Assertion macros for the quadratic root solver.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef QUADRATIC_REAL_ROOTS_DEFINES_SVH
`define QUADRATIC_REAL_ROOTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QRR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qrr assertion failed (same cycle)");
`define QRR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qrr assertion failed (next cycle)");
`else
`define QRR_ASSERT_IMPL(name, ante, cons)
`define QRR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/qrr_pkg.sv =====
// Shared constants, widths and item structures of the quadratic root solver.
// Used by every module of the solver; depends on nothing.
package qrr_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PROD_W = 2 * COEF_WIDTH;
    localparam int DISC_W = 2 * COEF_WIDTH + 2;
    localparam int ROOT_W = COEF_WIDTH + FRAC_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int NUM_W  = ROOT_W + 1;
    localparam int M1_W   = COEF_WIDTH + FRAC_BITS;
    localparam int DEN_W  = COEF_WIDTH + 1;

    localparam int IN_TDATA_W    = ((3 * COEF_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 2 + 2 * COEF_WIDTH + 1;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2
    } root_kind_t;

    typedef struct packed {
        logic                  sa;
        logic                  sb;
        logic [COEF_WIDTH-1:0] ma;
        logic [COEF_WIDTH-1:0] mb;
        root_kind_t            kind;
    } ctx_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic             sa;
        root_kind_t       kind;
        logic [DEN_W-1:0] den;
        lane_t [1:0]      lane;
    } div_t;

endpackage

// ===== rtl/qrr_front.sv =====
// Front end: coefficient magnitudes, products and the discriminant.
// Two register stages; uses qrr_pkg.
module qrr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [qrr_pkg::COEF_WIDTH-1:0]  coef_square,
    input  logic [qrr_pkg::COEF_WIDTH-1:0]  coef_linear,
    input  logic [qrr_pkg::COEF_WIDTH-1:0]  coef_constant,
    output logic                            out_valid,
    output qrr_pkg::sqrt_t                  out_data
);

    logic [qrr_pkg::COEF_WIDTH-1:0] ma, mb, mc;
    logic [qrr_pkg::PROD_W-1:0]     b2_next, p_next;

    logic                           s1_valid_reg;
    logic                           s1_sa_reg, s1_sb_reg, s1_sc_reg, s1_azero_reg;
    logic [qrr_pkg::COEF_WIDTH-1:0] s1_ma_reg, s1_mb_reg;
    logic [qrr_pkg::PROD_W-1:0]     s1_b2_reg, s1_p_reg;

    logic [qrr_pkg::DISC_W-1:0]     disc;
    qrr_pkg::sqrt_t                 s2_next, s2_reg;
    logic                           s2_valid_reg;

    assign ma = coef_square[qrr_pkg::COEF_WIDTH-1]   ? (~coef_square + 1'b1)   : coef_square;
    assign mb = coef_linear[qrr_pkg::COEF_WIDTH-1]   ? (~coef_linear + 1'b1)   : coef_linear;
    assign mc = coef_constant[qrr_pkg::COEF_WIDTH-1] ? (~coef_constant + 1'b1) : coef_constant;

    assign b2_next = mb * mb;
    assign p_next  = ma * mc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sa_reg    <= coef_square[qrr_pkg::COEF_WIDTH-1];
            s1_sb_reg    <= coef_linear[qrr_pkg::COEF_WIDTH-1];
            s1_sc_reg    <= coef_constant[qrr_pkg::COEF_WIDTH-1];
            s1_azero_reg <= (ma == '0);
            s1_ma_reg    <= ma;
            s1_mb_reg    <= mb;
            s1_b2_reg    <= b2_next;
            s1_p_reg     <= p_next;
            s2_reg       <= s2_next;
        end
    end

    // With equal signs of a2 and a0 the product term is subtracted.
    assign disc = (s1_sa_reg == s1_sc_reg)
                ? ({2'b00, s1_b2_reg} - {s1_p_reg, 2'b00})
                : ({2'b00, s1_b2_reg} + {s1_p_reg, 2'b00});

    always_comb begin
        s2_next          = '0;
        s2_next.ctx.sa   = s1_sa_reg;
        s2_next.ctx.sb   = s1_sb_reg;
        s2_next.ctx.ma   = s1_ma_reg;
        s2_next.ctx.mb   = s1_mb_reg;
        s2_next.rad      = qrr_pkg::RAD_W'(disc[qrr_pkg::DISC_W-2:0]) << (2 * qrr_pkg::FRAC_BITS);
        priority if (s1_azero_reg || disc[qrr_pkg::DISC_W-1]) begin
            s2_next.ctx.kind = qrr_pkg::KIND_NONE;
        end else if (disc == '0) begin
            s2_next.ctx.kind = qrr_pkg::KIND_ONE;
        end else begin
            s2_next.ctx.kind = qrr_pkg::KIND_TWO;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

// ===== rtl/qrr_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cycle while en is high.
// Uses qrr_pkg.
module qrr_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  qrr_pkg::sqrt_t in_data,
    output logic           out_valid,
    output qrr_pkg::sqrt_t out_data
);

    logic [qrr_pkg::SREM_W-1:0] rem_sh, trial;
    logic                       take;
    qrr_pkg::sqrt_t             data_next, data_reg;
    logic                       valid_reg;

    assign rem_sh = {in_data.rem[qrr_pkg::SREM_W-3:0], in_data.rad[qrr_pkg::RAD_W-1 -: 2]};
    assign trial  = {in_data.root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_comb begin
        data_next      = in_data;
        data_next.rad  = in_data.rad << 2;
        data_next.rem  = take ? (rem_sh - trial) : rem_sh;
        data_next.root = {in_data.root[qrr_pkg::ROOT_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/qrr_div_cell.sv =====
// One cell of the divider chain: one quotient bit per cycle for both roots while en is high.
// Uses qrr_pkg.
module qrr_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  qrr_pkg::div_t in_data,
    output logic          out_valid,
    output qrr_pkg::div_t out_data
);

    qrr_pkg::div_t data_next, data_reg;
    logic          valid_reg;

    always_comb begin
        logic [qrr_pkg::DEN_W:0] rem_sh;
        logic [qrr_pkg::DEN_W:0] den_x;
        logic                    take;
        data_next = in_data;
        den_x     = {1'b0, in_data.den};
        for (int i = 0; i < 2; i++) begin
            rem_sh = {in_data.lane[i].rem, in_data.lane[i].num[qrr_pkg::NUM_W-1]};
            take   = (rem_sh >= den_x);
            data_next.lane[i].rem = take ? qrr_pkg::DEN_W'(rem_sh - den_x)
                                         : rem_sh[qrr_pkg::DEN_W-1:0];
            data_next.lane[i].num = in_data.lane[i].num << 1;
            data_next.lane[i].quo = {in_data.lane[i].quo[qrr_pkg::NUM_W-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/quadratic_real_roots.sv =====
// Real roots of a quadratic in signed Q16.16: front end, square root cell chain,
// numerator stage, divider cell chain, clamp and output register.
// From item acceptance to m_tvalid an item passes through 2 front stages,
// 49 root cells, 1 numerator stage, 50 divider cells and the output register.
// Throughput is one item per cycle; a stalled output holds the chain only once
// the last cell is full. Reset empties all stages and the output register.
`include "quadratic_real_roots_defines.svh"
module quadratic_real_roots (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // coef_square, coef_linear, coef_constant
    input  logic [qrr_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // root_count, root_low, root_high, saturated, zero fill
    output logic [qrr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int W = qrr_pkg::COEF_WIDTH;
    localparam logic [qrr_pkg::NUM_W-1:0] POS_LIM =
        qrr_pkg::NUM_W'((128'd1 << (W - 1)) - 128'd1);
    localparam logic [qrr_pkg::NUM_W-1:0] NEG_LIM =
        qrr_pkg::NUM_W'(128'd1 << (W - 1));

    logic adv, out_free;

    logic           sq_vld [qrr_pkg::ROOT_W+1];
    qrr_pkg::sqrt_t sq_bus [qrr_pkg::ROOT_W+1];
    logic           dv_vld [qrr_pkg::NUM_W+1];
    qrr_pkg::div_t  dv_bus [qrr_pkg::NUM_W+1];

    qrr_pkg::div_t  num_next, num_reg;
    logic           num_valid_reg;

    logic                  m_tvalid_reg;
    qrr_pkg::root_kind_t   m_count_reg, count_next;
    logic [W-1:0]          m_low_reg, m_high_reg, low_next, high_next;
    logic                  m_sat_reg, sat_next;
    logic [W:0]            r0, r1;

    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = out_free || !dv_vld[qrr_pkg::NUM_W];
    assign s_tready = adv;

    qrr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (s_tvalid),
        .coef_square   (s_tdata[W-1:0]),
        .coef_linear   (s_tdata[2*W-1:W]),
        .coef_constant (s_tdata[3*W-1:2*W]),
        .out_valid     (sq_vld[0]),
        .out_data      (sq_bus[0])
    );

    for (genvar k = 0; k < qrr_pkg::ROOT_W; k++) begin : g_sqrt
        qrr_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_vld[k]),
            .in_data   (sq_bus[k]),
            .out_valid (sq_vld[k+1]),
            .out_data  (sq_bus[k+1])
        );
    end

    // Numerators -a1*2^F - S and -a1*2^F + S in sign and magnitude.
    always_comb begin
        logic signed [qrr_pkg::NUM_W:0] mval, sval, nm, np;
        qrr_pkg::sqrt_t                 sq;
        sq   = sq_bus[qrr_pkg::ROOT_W];
        mval = $signed((qrr_pkg::NUM_W + 1)'(qrr_pkg::M1_W'(sq.ctx.mb) << qrr_pkg::FRAC_BITS));
        if (!sq.ctx.sb) begin
            mval = -mval;
        end
        sval = $signed((qrr_pkg::NUM_W + 1)'(sq.root));
        nm   = mval - sval;
        np   = mval + sval;
        num_next              = '0;
        num_next.sa           = sq.ctx.sa;
        num_next.kind         = sq.ctx.kind;
        num_next.den          = {sq.ctx.ma, 1'b0};
        num_next.lane[0].neg  = nm[qrr_pkg::NUM_W];
        num_next.lane[0].num  = nm[qrr_pkg::NUM_W] ? qrr_pkg::NUM_W'(-nm)
                                                   : qrr_pkg::NUM_W'(nm);
        num_next.lane[1].neg  = np[qrr_pkg::NUM_W];
        num_next.lane[1].num  = np[qrr_pkg::NUM_W] ? qrr_pkg::NUM_W'(-np)
                                                   : qrr_pkg::NUM_W'(np);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_valid_reg <= 1'b0;
        end else if (adv) begin
            num_valid_reg <= sq_vld[qrr_pkg::ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg <= num_next;
        end
    end

    assign dv_vld[0] = num_valid_reg;
    assign dv_bus[0] = num_reg;

    for (genvar k = 0; k < qrr_pkg::NUM_W; k++) begin : g_div
        qrr_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (dv_vld[k]),
            .in_data   (dv_bus[k]),
            .out_valid (dv_vld[k+1]),
            .out_data  (dv_bus[k+1])
        );
    end

    // Returns {saturated, root} for a quotient magnitude and its sign.
    function automatic logic [W:0] clamp_root(input logic neg_in,
                                              input logic [qrr_pkg::NUM_W-1:0] q);
        logic neg;
        neg = neg_in && (q != '0);
        if (!neg) begin
            if (q > POS_LIM) begin
                return {1'b1, W'(POS_LIM)};
            end
            return {1'b0, q[W-1:0]};
        end
        if (q > NEG_LIM) begin
            return {1'b1, W'(NEG_LIM)};
        end
        return {1'b0, W'(~q[W-1:0] + 1'b1)};
    endfunction

    always_comb begin
        qrr_pkg::div_t d;
        d          = dv_bus[qrr_pkg::NUM_W];
        r0         = clamp_root(d.lane[0].neg ^ d.sa, d.lane[0].quo);
        r1         = clamp_root(d.lane[1].neg ^ d.sa, d.lane[1].quo);
        count_next = d.kind;
        low_next   = '0;
        high_next  = '0;
        sat_next   = 1'b0;
        unique case (d.kind)
            qrr_pkg::KIND_ONE: begin
                low_next = r0[W-1:0];
                sat_next = r0[W];
            end
            qrr_pkg::KIND_TWO: begin
                low_next  = d.sa ? r1[W-1:0] : r0[W-1:0];
                high_next = d.sa ? r0[W-1:0] : r1[W-1:0];
                sat_next  = r0[W] | r1[W];
            end
            default: begin
                count_next = qrr_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= dv_vld[qrr_pkg::NUM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_count_reg <= count_next;
            m_low_reg   <= low_next;
            m_high_reg  <= high_next;
            m_sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = qrr_pkg::OUT_TDATA_W'({m_sat_reg, m_high_reg, m_low_reg, m_count_reg});

    `QRR_ASSERT_IMPL(a_none_is_zero, m_tvalid_reg && (m_count_reg == qrr_pkg::KIND_NONE), (m_low_reg == '0) && (m_high_reg == '0) && !m_sat_reg)
    `QRR_ASSERT_IMPL(a_one_high_zero, m_tvalid_reg && (m_count_reg == qrr_pkg::KIND_ONE), m_high_reg == '0)
    `QRR_ASSERT_IMPL(a_two_ordered, m_tvalid_reg && (m_count_reg == qrr_pkg::KIND_TWO), $signed(m_low_reg) <= $signed(m_high_reg))
    `QRR_ASSERT_NEXT(a_last_cell_held, dv_vld[qrr_pkg::NUM_W] && !adv, dv_vld[qrr_pkg::NUM_W])

endmodule
